// ===== hdl/top_k_score_selector_defines.svh =====
// Assertion macros shared by the top-k score selector.
`ifndef TOP_K_SCORE_SELECTOR_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TKS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/tks_pkg.sv =====
// Package with types and constants for the top-k score selector.
package tks_pkg;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CcW    = 11;
  localparam int unsigned KcW    = 5;
  localparam logic CfgClassCount = 1'b0;
  localparam logic CfgKeepCount  = 1'b1;
  localparam logic [ScoreW-1:0] NegZero = 32'h8000_0000;

  // Order-preserving key: unsigned compare matches float compare, -0 folded into +0.
  function automatic logic [ScoreW-1:0] order_key(input logic [ScoreW-1:0] bits);
    logic [ScoreW-1:0] b;
    b = (bits == NegZero) ? '0 : bits;
    order_key = b[ScoreW-1] ? ~b : (b | NegZero);
  endfunction
endpackage

// ===== hdl/tks_front.sv =====
// Front part: counts row position, forms sort keys and flags row ends.
module tks_front #(
  parameter int unsigned MAX_CLASSES = 1024,
  parameter int unsigned MAX_KEEP    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [tks_pkg::ScoreW-1:0] score,
  input  logic [tks_pkg::CcW-1:0]   class_count,
  input  logic [tks_pkg::KcW-1:0]   keep_count,
  input  logic                      cmd_ready,
  output logic                      cmd_valid_r,
  output logic [tks_pkg::ScoreW-1:0] cmd_key_r,
  output logic [tks_pkg::IdxW-1:0]  cmd_idx_r,
  output logic                      cmd_end_r,
  output logic [$clog2(MAX_KEEP+1)-1:0] cmd_keep_r
);
  localparam int unsigned PosW = $clog2(MAX_CLASSES);
  localparam int unsigned KW   = $clog2(MAX_KEEP+1);
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW:0]   eff_cls;
  logic [KW-1:0]   eff_keep;
  logic            row_end;

  always_comb begin
    if (class_count == '0) eff_cls = (PosW+1)'(1);
    else if (32'(class_count) > MAX_CLASSES) eff_cls = (PosW+1)'(MAX_CLASSES);
    else eff_cls = (PosW+1)'(class_count);
    if (keep_count == '0) eff_keep = KW'(1);
    else if (32'(keep_count) > MAX_KEEP) eff_keep = KW'(MAX_KEEP);
    else eff_keep = KW'(keep_count);
    row_end = ({1'b0, pos_r} + (PosW+1)'(1)) >= eff_cls;
    pos_nxt = row_end ? '0 : pos_r + PosW'(1);
  end

  // The command register holds its item while the back part refuses it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      if (!cmd_valid_r || cmd_ready) cmd_valid_r <= in_fire;
      if (in_fire) pos_r <= pos_nxt;
    end
    if (in_fire) begin
      cmd_key_r  <= tks_pkg::order_key(score);
      cmd_idx_r  <= tks_pkg::IdxW'(pos_r);
      cmd_end_r  <= row_end;
      cmd_keep_r <= eff_keep;
    end
  end
endmodule

// ===== hdl/tks_back.sv =====
// Back part: parallel compare-insert list and result queue drain.
module tks_back #(
  parameter int unsigned MAX_KEEP = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  logic [tks_pkg::ScoreW-1:0] cmd_key,
  input  logic [tks_pkg::IdxW-1:0]  cmd_idx,
  input  logic                      cmd_end,
  input  logic [$clog2(MAX_KEEP+1)-1:0] cmd_keep,
  output logic                      cmd_ready,
  output logic                      out_valid_r,
  input  logic                      out_ready,
  output logic [tks_pkg::IdxW-1:0]  out_idx_r,
  output logic                      out_last_r
);
  localparam int unsigned KW = $clog2(MAX_KEEP+1);
  localparam int unsigned SW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  logic [tks_pkg::ScoreW-1:0] key_r [MAX_KEEP];
  logic [tks_pkg::IdxW-1:0]   idx_r [MAX_KEEP];
  logic [tks_pkg::IdxW-1:0]   hold_r [MAX_KEEP];
  logic [KW-1:0] filled_r, hold_cnt_r, rd_r;
  logic [KW-1:0] filled, fnew;
  logic [MAX_KEEP-1:0] ge;
  logic [KW-1:0] slot;
  logic [tks_pkg::ScoreW-1:0] nkey [MAX_KEEP];
  logic [tks_pkg::IdxW-1:0]   nidx [MAX_KEEP];
  logic drain, take, last_one, hold_free, accept;

  // Entries with key >= new form a prefix, so the slot is their count.
  always_comb begin
    filled = (filled_r > cmd_keep) ? cmd_keep : filled_r;
    slot = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = (KW'(i) < filled) && (key_r[i] >= cmd_key);
      slot = slot + KW'(ge[i]);
    end
    fnew = filled;
    if (slot < cmd_keep && filled < cmd_keep) fnew = filled + KW'(1);
    for (int i = 0; i < MAX_KEEP; i++) begin
      nkey[i] = key_r[i];
      nidx[i] = idx_r[i];
      if (slot < cmd_keep) begin
        if (KW'(i) == slot) begin
          nkey[i] = cmd_key;
          nidx[i] = cmd_idx;
        end else if (KW'(i) > slot && i > 0) begin
          nkey[i] = key_r[(i > 0) ? i-1 : 0];
          nidx[i] = idx_r[(i > 0) ? i-1 : 0];
        end
      end
    end
  end

  assign drain     = hold_cnt_r != '0;
  assign take      = !out_valid_r || out_ready;
  assign last_one  = (rd_r + KW'(1)) == hold_cnt_r;
  // The hold bank can take a new row when it is empty or once its last item leaves in this cycle.
  assign hold_free = !drain || (take && last_one);
  assign cmd_ready = !(cmd_valid && cmd_end) || hold_free;
  assign accept    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      hold_cnt_r <= '0;
      rd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= drain;
        if (drain) begin
          out_last_r <= last_one;
          if (last_one) rd_r <= '0;
          else rd_r <= rd_r + KW'(1);
        end
      end
      if (accept) filled_r <= cmd_end ? '0 : fnew;
      if (accept && cmd_end) hold_cnt_r <= fnew;
      else if (take && drain && last_one) hold_cnt_r <= '0;
    end
    if (take && drain) out_idx_r <= hold_r[rd_r[SW-1:0]];
    if (accept) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        key_r[i] <= nkey[i];
        idx_r[i] <= nidx[i];
        if (cmd_end) hold_r[i] <= nidx[i];
      end
    end
  end
endmodule

// ===== hdl/top_k_score_selector.sv =====
// Top level of the streaming stable top-k score selector.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata[31:0] score_bits
//  out_    | out | out_tvalid/out_tready| tdata[9:0] class_index, tlast row_last
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One score item is taken per cycle while in_tready is high; the combinational
// compare-insert over all kept entries in the back part acts on the front register.
// At the end of a row the ranked indices are copied into a hold bank and drained
// at one item per cycle while out_tready is high; each result is registered.
// A row end waits in the front register, stalling input, only while the
// previous row still occupies the hold bank, which with a ready receiver
// never happens, as a row has at least as many items as results.
// Reset (synchronous, active low) empties the list and row position.
`include "top_k_score_selector_defines.svh"
module top_k_score_selector #(
  parameter int unsigned MAX_CLASSES = 1024,
  parameter int unsigned MAX_KEEP    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] score_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] class_index, rest zero
  output logic        out_tlast,  // row_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned KW = $clog2(MAX_KEEP+1);
  logic [tks_pkg::CcW-1:0] class_count_r;
  logic [tks_pkg::KcW-1:0] keep_count_r;
  logic in_fire, cmd_ready, cmd_valid, cmd_end;
  logic [tks_pkg::ScoreW-1:0] cmd_key;
  logic [tks_pkg::IdxW-1:0] cmd_idx, out_idx;
  logic [KW-1:0] cmd_keep;

  assign cfg_ready = 1'b1;
  // The front register forms a one-item queue: a new item enters when it is
  // empty or when the back part takes its current item in this cycle.
  assign in_tready = !cmd_valid || cmd_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {6'b0, out_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= 11'd1000;
      keep_count_r  <= 5'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        tks_pkg::CfgClassCount: class_count_r <= cfg_data[tks_pkg::CcW-1:0];
        tks_pkg::CfgKeepCount:  keep_count_r  <= cfg_data[tks_pkg::KcW-1:0];
        default: ;
      endcase
    end
  end

  tks_front #(.MAX_CLASSES(MAX_CLASSES), .MAX_KEEP(MAX_KEEP)) u_front (
    .clk, .rst_n, .in_fire, .score(in_tdata),
    .class_count(class_count_r), .keep_count(keep_count_r), .cmd_ready,
    .cmd_valid_r(cmd_valid), .cmd_key_r(cmd_key), .cmd_idx_r(cmd_idx),
    .cmd_end_r(cmd_end), .cmd_keep_r(cmd_keep)
  );

  tks_back #(.MAX_KEEP(MAX_KEEP)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_key, .cmd_idx, .cmd_end, .cmd_keep,
    .cmd_ready, .out_valid_r(out_tvalid), .out_ready(out_tready),
    .out_idx_r(out_idx), .out_last_r(out_tlast)
  );

  `TKS_ASSERT_IMPL(a_no_overrun, cmd_valid && !cmd_ready, !in_tready, "queue overrun")
  `TKS_ASSERT_NEXT(a_hold_out, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result dropped")
  `TKS_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && cmd_end, "row end lost")
endmodule
